[design/tbda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tbda_pkg;

  localparam int NUM_AXES    = 4;
  localparam int NUM_BUTTONS = 8;

  typedef logic [NUM_BUTTONS-1:0] btn_vec_t;
  typedef logic signed [7:0]      trim_t;
  typedef logic [2:0]             btn_idx_t;

  typedef struct packed {
    btn_vec_t press_fire;
    btn_vec_t rep_fire;
    btn_vec_t stable;
  } fire_t;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE_SAMPLES   = 3'd0,
    CFG_HOLD_DELAY_MS      = 3'd1,
    CFG_REPEAT_INTERVAL_MS = 3'd2,
    CFG_TRIM_STEP          = 3'd3,
    CFG_TRIM_LIMIT         = 3'd4
  } cfg_idx_t;

  // button map: axis 0 <- bits 0/1, axis 1 <- bits 6/7, axis 2 <- bits 4/5, axis 3 <- bits 2/3
  localparam btn_idx_t AXIS_UP_BTN [NUM_AXES] = '{3'd0, 3'd6, 3'd4, 3'd2};
  localparam btn_idx_t AXIS_DN_BTN [NUM_AXES] = '{3'd1, 3'd7, 3'd5, 3'd3};

  localparam logic [7:0]  DEF_DEBOUNCE_SAMPLES   = 8'd3;
  localparam logic [15:0] DEF_HOLD_DELAY_MS      = 16'd400;
  localparam logic [15:0] DEF_REPEAT_INTERVAL_MS = 16'd100;
  localparam logic [6:0]  DEF_TRIM_STEP          = 7'd2;
  localparam logic [6:0]  DEF_TRIM_LIMIT         = 7'd100;

  function automatic trim_t trim_apply(trim_t v, logic up, logic [6:0] step,
                                       logic [6:0] lim);
    logic signed [8:0] s;
    logic signed [8:0] hi;
    logic signed [8:0] lo;
    hi = $signed({2'b00, lim});
    lo = -hi;
    if (up) begin
      s = $signed({v[7], v}) + $signed({2'b00, step});
    end else begin
      s = $signed({v[7], v}) - $signed({2'b00, step});
    end
    if (s > hi) begin
      s = hi;
    end else if (s < lo) begin
      s = lo;
    end
    return s[7:0];
  endfunction

endpackage
`default_nettype wire

[design/tbda_debounce.sv]
`timescale 1ns / 1ps
`default_nettype none
module tbda_debounce (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire tbda_pkg::btn_vec_t raw,
  input  wire logic [31:0]       now,
  input  wire logic [7:0]        debounce_samples,
  input  wire logic [15:0]       hold_delay_ms,
  input  wire logic [15:0]       repeat_interval_ms,
  output tbda_pkg::fire_t        fire_r
);
  import tbda_pkg::*;

  btn_vec_t    stable_r, cand_r;
  logic [7:0]  cnt_r;
  logic [31:0] ps_r [NUM_BUTTONS];
  logic [31:0] lf_r [NUM_BUTTONS];

  btn_vec_t    stable_nxt, pressed, press, release_b, rep;
  logic [7:0]  cnt_nxt;
  logic [31:0] now1;
  logic        accept;
  logic [31:0] ps_nxt [NUM_BUTTONS];
  logic [31:0] lf_mid [NUM_BUTTONS];
  logic [31:0] lf_nxt [NUM_BUTTONS];
  logic [31:0] held   [NUM_BUTTONS];
  logic [31:0] since  [NUM_BUTTONS];

  always_comb begin
    now1 = (now == 32'd0) ? 32'd1 : now;
    if (raw == cand_r) begin
      cnt_nxt = (cnt_r < debounce_samples) ? cnt_r + 8'd1 : cnt_r;
    end else begin
      cnt_nxt = 8'd1;
    end
    accept     = (cnt_nxt >= debounce_samples);
    stable_nxt = accept ? raw : stable_r;
    pressed    = ~stable_nxt;
    press      = pressed & stable_r;
    release_b  = stable_nxt & ~stable_r;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (press[b]) begin
        ps_nxt[b] = now1;
        lf_mid[b] = now1;
      end else if (release_b[b]) begin
        ps_nxt[b] = 32'd0;
        lf_mid[b] = 32'd0;
      end else begin
        ps_nxt[b] = ps_r[b];
        lf_mid[b] = lf_r[b];
      end
      held[b]  = now1 - ps_nxt[b];
      since[b] = now1 - lf_mid[b];
      rep[b]   = (ps_nxt[b] != 32'd0) && pressed[b] &&
                 (held[b] >= {16'd0, hold_delay_ms}) &&
                 (since[b] >= {16'd0, repeat_interval_ms});
      lf_nxt[b] = rep[b] ? now1 : lf_mid[b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '1;
      cand_r   <= '1;
      cnt_r    <= 8'd0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        ps_r[b] <= 32'd0;
        lf_r[b] <= 32'd0;
      end
    end else if (go) begin
      stable_r <= stable_nxt;
      cand_r   <= raw;
      cnt_r    <= cnt_nxt;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        ps_r[b] <= ps_nxt[b];
        lf_r[b] <= lf_nxt[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      fire_r.press_fire <= press;
      fire_r.rep_fire   <= rep;
      fire_r.stable     <= stable_nxt;
    end
  end

endmodule
`default_nettype wire

[design/tbda_trim.sv]
`timescale 1ns / 1ps
`default_nettype none
module tbda_trim (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire tbda_pkg::fire_t    fire,
  input  wire logic [6:0]         step_size,
  input  wire logic [6:0]         trim_limit,
  output tbda_pkg::trim_t         trim_r [tbda_pkg::NUM_AXES],
  output tbda_pkg::btn_vec_t      stable_r,
  output logic                    changed_r
);
  import tbda_pkg::*;

  trim_t trim_nxt [NUM_AXES];
  trim_t v;

  // firings per axis in bit order: presses first, then repeats
  always_comb begin
    v = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      v = trim_r[a];
      if (fire.press_fire[AXIS_UP_BTN[a]]) v = trim_apply(v, 1'b1, step_size, trim_limit);
      if (fire.press_fire[AXIS_DN_BTN[a]]) v = trim_apply(v, 1'b0, step_size, trim_limit);
      if (fire.rep_fire[AXIS_UP_BTN[a]])   v = trim_apply(v, 1'b1, step_size, trim_limit);
      if (fire.rep_fire[AXIS_DN_BTN[a]])   v = trim_apply(v, 1'b0, step_size, trim_limit);
      trim_nxt[a] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        trim_r[a] <= '0;
      end
    end else if (go) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        trim_r[a] <= trim_nxt[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      stable_r  <= fire.stable;
      changed_r <= |{fire.press_fire, fire.rep_fire};
    end
  end

endmodule
`default_nettype wire

[design/trim_button_debounce_autorepeat.sv]
`timescale 1ns / 1ps
`default_nettype none
// Trim button debounce with auto-repeat. One result per input transaction,
// one transaction per clock sustained while out_stall is low. The path runs: input
// register, then the debounce/timing stage (equal-sample count, press and
// release edges, 32-bit wrapped hold and repeat compares for all eight
// buttons in parallel), then the trim stage (up to four saturating steps
// per axis in bit order) which feeds the result register. Trim offsets are
// held in the result register itself. The configuration port is always
// ready; write it only while no transaction is in flight.
module trim_button_debounce_autorepeat (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_buttons_raw,
  input  wire logic [31:0]       in_now_ms,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [7:0]      out_trim_throttle,
  output logic signed [7:0]      out_trim_yaw,
  output logic signed [7:0]      out_trim_pitch,
  output logic signed [7:0]      out_trim_roll,
  output logic [7:0]             out_stable_buttons,
  output logic                   out_trims_changed,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import tbda_pkg::*;

  logic        in_valid_r, dec_valid_r, out_valid_r;
  btn_vec_t    raw_r;
  logic [31:0] now_r;

  logic [7:0]  debounce_samples_r;
  logic [15:0] hold_delay_ms_r;
  logic [15:0] repeat_interval_ms_r;
  logic [6:0]  step_size_r;
  logic [6:0]  trim_limit_r;

  logic        out_free, dec_free, dec_go, in_go, in_take;
  fire_t       fire_r;
  trim_t       trim_r [NUM_AXES];
  btn_vec_t    stable_r;
  logic        changed_r;

  assign out_free = ~out_valid_r | ~out_stall;
  assign dec_go   = dec_valid_r & out_free;
  assign dec_free = ~dec_valid_r | out_free;
  assign in_go    = in_valid_r & dec_free;
  assign in_stall = in_valid_r & ~dec_free;
  assign in_take  = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      dec_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (dec_free)  dec_valid_r <= in_valid_r;
      if (out_free)  out_valid_r <= dec_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_r <= in_buttons_raw;
      now_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_samples_r   <= DEF_DEBOUNCE_SAMPLES;
      hold_delay_ms_r      <= DEF_HOLD_DELAY_MS;
      repeat_interval_ms_r <= DEF_REPEAT_INTERVAL_MS;
      step_size_r          <= DEF_TRIM_STEP;
      trim_limit_r         <= DEF_TRIM_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE_SAMPLES:   debounce_samples_r   <= cfg_data[7:0];
        CFG_HOLD_DELAY_MS:      hold_delay_ms_r      <= cfg_data;
        CFG_REPEAT_INTERVAL_MS: repeat_interval_ms_r <= cfg_data;
        CFG_TRIM_STEP:          step_size_r          <= cfg_data[6:0];
        CFG_TRIM_LIMIT:         trim_limit_r         <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  tbda_debounce u_debounce (
    .clk                (clk),
    .rst_n              (rst_n),
    .go                 (in_go),
    .raw                (raw_r),
    .now                (now_r),
    .debounce_samples   (debounce_samples_r),
    .hold_delay_ms      (hold_delay_ms_r),
    .repeat_interval_ms (repeat_interval_ms_r),
    .fire_r             (fire_r)
  );

  tbda_trim u_trim (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (dec_go),
    .fire       (fire_r),
    .step_size  (step_size_r),
    .trim_limit (trim_limit_r),
    .trim_r     (trim_r),
    .stable_r   (stable_r),
    .changed_r  (changed_r)
  );

  assign out_valid          = out_valid_r;
  assign out_trim_throttle  = trim_r[0];
  assign out_trim_yaw       = trim_r[1];
  assign out_trim_pitch     = trim_r[2];
  assign out_trim_roll      = trim_r[3];
  assign out_stable_buttons = stable_r;
  assign out_trims_changed  = changed_r;

  a_trim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_trim_throttle != 8'sh80 && out_trim_yaw != 8'sh80 &&
    out_trim_pitch != 8'sh80 && out_trim_roll != 8'sh80)
    else $error("trim offset outside symmetric range");

  a_trim_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !dec_go |=> $stable(out_trim_throttle) && $stable(out_trim_yaw) &&
                         $stable(out_trim_pitch) && $stable(out_trim_roll))
    else $error("trim offsets moved without a transaction in the trim stage");

  a_dec_kept: assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid_r && !out_free |=> dec_valid_r)
    else $error("decision stage transaction dropped");

endmodule
`default_nettype wire

[tb/trim_tick_checker.sv]
`timescale 1ns / 1ps
module trim_tick_checker
  import tbda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_buttons_raw,
  input  logic [31:0]       in_now_ms,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic signed [7:0] out_trim_throttle,
  input  logic signed [7:0] out_trim_yaw,
  input  logic signed [7:0] out_trim_pitch,
  input  logic signed [7:0] out_trim_roll,
  input  logic [7:0]        out_stable_buttons,
  input  logic              out_trims_changed,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                fail_count,
  output int                pending_count,
  output int                checked_count,
  output int                active_count
);

  typedef struct packed {
    trim_t    throttle;
    trim_t    yaw;
    trim_t    pitch;
    trim_t    roll;
    btn_vec_t stable;
    logic     changed;
  } trim_snapshot_t;

  logic [7:0]     db_samples;
  logic [15:0]    hold_ms;
  logic [15:0]    rep_ms;
  logic [6:0]     step_amt;
  logic [6:0]     lim_amt;
  btn_vec_t       stable_btn;
  btn_vec_t       cand_btn;
  logic [7:0]     cand_cnt;
  logic [31:0]    press_ms    [NUM_BUTTONS];
  logic [31:0]    last_rep_ms [NUM_BUTTONS];
  trim_t          trims       [NUM_AXES];
  trim_snapshot_t expected_trims[$];
  trim_snapshot_t want;
  trim_snapshot_t got;
  int             errs = 0;
  int             n_checked = 0;
  int             n_active = 0;

  function automatic void clear_model();
    db_samples = DEF_DEBOUNCE_SAMPLES;
    hold_ms    = DEF_HOLD_DELAY_MS;
    rep_ms     = DEF_REPEAT_INTERVAL_MS;
    step_amt   = DEF_TRIM_STEP;
    lim_amt    = DEF_TRIM_LIMIT;
    stable_btn = '1;
    cand_btn   = '1;
    cand_cnt   = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      press_ms[b]    = '0;
      last_rep_ms[b] = '0;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      trims[a] = '0;
    end
  endfunction

  function automatic void nudge_trim(int b);
    int   a;
    int   v;
    logic up;
    a  = 0;
    up = 1'b1;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (AXIS_UP_BTN[k] == b) begin
        a  = k;
        up = 1'b1;
      end
      if (AXIS_DN_BTN[k] == b) begin
        a  = k;
        up = 1'b0;
      end
    end
    v = int'(trims[a]) + (up ? int'(step_amt) : -int'(step_amt));
    if (v > int'(lim_amt)) v = int'(lim_amt);
    if (v < -int'(lim_amt)) v = -int'(lim_amt);
    trims[a] = trim_t'(v);
  endfunction

  function automatic trim_snapshot_t predict_tick(btn_vec_t raw, logic [31:0] t_in);
    logic [31:0]    t;
    logic [31:0]    held;
    logic [31:0]    since;
    btn_vec_t       prev;
    logic           fired;
    trim_snapshot_t r;
    t     = (t_in == 32'd0) ? 32'd1 : t_in;
    fired = 1'b0;
    if (raw == cand_btn) begin
      if (cand_cnt < db_samples) cand_cnt++;
    end else begin
      cand_btn = raw;
      cand_cnt = 8'd1;
    end
    if (cand_cnt >= db_samples) begin
      prev       = stable_btn;
      stable_btn = cand_btn;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (!stable_btn[b] && prev[b]) begin
          nudge_trim(b);
          fired          = 1'b1;
          press_ms[b]    = t;
          last_rep_ms[b] = t;
        end else if (stable_btn[b] && !prev[b]) begin
          press_ms[b]    = '0;
          last_rep_ms[b] = '0;
        end
      end
    end
    // auto-repeat, elapsed times wrap
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (press_ms[b] != 32'd0 && !stable_btn[b]) begin
        held  = t - press_ms[b];
        since = t - last_rep_ms[b];
        if (held >= {16'd0, hold_ms} && since >= {16'd0, rep_ms}) begin
          nudge_trim(b);
          fired          = 1'b1;
          last_rep_ms[b] = t;
        end
      end
    end
    r.throttle = trims[0];
    r.yaw      = trims[1];
    r.pitch    = trims[2];
    r.roll     = trims[3];
    r.stable   = stable_btn;
    r.changed  = fired;
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endfunction

  initial clear_model();

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      expected_trims.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DEBOUNCE_SAMPLES:   db_samples = cfg_data[7:0];
          CFG_HOLD_DELAY_MS:      hold_ms    = cfg_data;
          CFG_REPEAT_INTERVAL_MS: rep_ms     = cfg_data;
          CFG_TRIM_STEP:          step_amt   = cfg_data[6:0];
          CFG_TRIM_LIMIT:         lim_amt    = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_trim_throttle, out_trim_yaw, out_trim_pitch, out_trim_roll,
               out_stable_buttons, out_trims_changed};
        if (expected_trims.size() == 0) begin
          $error("result transaction with no tick outstanding: %h", got);
          errs++;
        end else begin
          want = expected_trims.pop_front();
          n_checked++;
          if (want.changed) n_active++;
          if ($isunknown(got)) begin
            $error("result carries unknown bits: %h", got);
            errs++;
          end
          check_field("trim_throttle", int'($signed(want.throttle)), int'(out_trim_throttle));
          check_field("trim_yaw", int'($signed(want.yaw)), int'(out_trim_yaw));
          check_field("trim_pitch", int'($signed(want.pitch)), int'(out_trim_pitch));
          check_field("trim_roll", int'($signed(want.roll)), int'(out_trim_roll));
          check_field("stable_buttons", int'(want.stable), int'(out_stable_buttons));
          check_field("trims_changed", int'(want.changed), int'(out_trims_changed));
        end
      end
      if (in_valid && !in_stall) begin
        expected_trims.push_back(predict_tick(in_buttons_raw, in_now_ms));
      end
    end
    fail_count    <= errs;
    pending_count <= expected_trims.size();
    checked_count <= n_checked;
    active_count  <= n_active;
  end

endmodule

[tb/tb_trim_button_debounce_autorepeat.sv]
`timescale 1ns / 1ps
module tb_trim_button_debounce_autorepeat;
  import tbda_pkg::*;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_BEAT, STALL_HEAVY} stall_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_buttons_raw = 8'hFF;
  logic [31:0]       in_now_ms = 32'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [7:0] out_trim_throttle;
  logic signed [7:0] out_trim_yaw;
  logic signed [7:0] out_trim_pitch;
  logic signed [7:0] out_trim_roll;
  logic [7:0]        out_stable_buttons;
  logic              out_trims_changed;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = CFG_DEBOUNCE_SAMPLES;
  logic [15:0]       cfg_data = 16'd0;

  int fail_count;
  int pending_count;
  int checked_count;
  int active_count;

  logic [7:0]  cfg_db   = DEF_DEBOUNCE_SAMPLES;
  logic [15:0] cfg_hold = DEF_HOLD_DELAY_MS;
  logic [15:0] cfg_rep  = DEF_REPEAT_INTERVAL_MS;
  logic [31:0] clock_ms = 32'd1000;

  stall_kind_t stall_mode = STALL_NONE;
  bit          gaps_on = 1'b0;
  int          burst_left = 0;
  int          sent = 0;
  int          settings = 0;
  int          holdoff_asked = 0;
  int          holdoff_given = 0;
  int          holdoff_left = 0;
  int          beat_cnt = 0;
  int          wait_cycles = 0;

  always #10 clk = ~clk;

  trim_button_debounce_autorepeat u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_buttons_raw     (in_buttons_raw),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_trim_throttle  (out_trim_throttle),
    .out_trim_yaw       (out_trim_yaw),
    .out_trim_pitch     (out_trim_pitch),
    .out_trim_roll      (out_trim_roll),
    .out_stable_buttons (out_stable_buttons),
    .out_trims_changed  (out_trims_changed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  trim_tick_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_buttons_raw     (in_buttons_raw),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_trim_throttle  (out_trim_throttle),
    .out_trim_yaw       (out_trim_yaw),
    .out_trim_pitch     (out_trim_pitch),
    .out_trim_roll      (out_trim_roll),
    .out_stable_buttons (out_stable_buttons),
    .out_trims_changed  (out_trims_changed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending_count      (pending_count),
    .checked_count      (checked_count),
    .active_count       (active_count)
  );

  // receiver back-pressure; long hold-offs counted here
  always @(posedge clk) begin
    beat_cnt = (beat_cnt + 1) % 5;
    if (holdoff_left == 0 && holdoff_given != holdoff_asked) begin
      holdoff_given++;
      holdoff_left = 90;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_BEAT:   out_stall <= (beat_cnt < 2);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  task automatic send_tick(input btn_vec_t raw, input logic [31:0] stamp);
    in_valid       <= 1'b1;
    in_buttons_raw <= raw;
    in_now_ms      <= stamp;
    do @(posedge clk); while (in_stall);
    sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_cfg(input logic [7:0] db, input logic [15:0] hold,
                           input logic [15:0] rep, input logic [6:0] step,
                           input logic [6:0] lim);
    drain();
    write_reg(CFG_DEBOUNCE_SAMPLES, {8'd0, db});
    write_reg(CFG_HOLD_DELAY_MS, hold);
    write_reg(CFG_REPEAT_INTERVAL_MS, rep);
    write_reg(CFG_TRIM_STEP, {9'd0, step});
    write_reg(CFG_TRIM_LIMIT, {9'd0, lim});
    cfg_valid <= 1'b0;
    cfg_db   = db;
    cfg_hold = hold;
    cfg_rep  = rep;
    settings++;
  endtask

  function automatic btn_vec_t pick_pattern();
    case ($urandom_range(0, 5))
      0:       return 8'hFF;
      1, 2:    return ~(8'h01 << $urandom_range(0, 7));
      3:       return ~((8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7)));
      4:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // held patterns long enough to debounce, with occasional bounce
  task automatic run_phase(input int budget, input bit holdoff, input bit pause);
    btn_vec_t    pat;
    btn_vec_t    raw;
    logic [31:0] stamp;
    int          span;
    int          run_len;
    int          n;
    n    = 0;
    span = (int'(cfg_hold) + int'(cfg_rep)) / 3 + 2;
    while (n < budget) begin
      pat     = pick_pattern();
      run_len = int'(cfg_db) + $urandom_range(0, 12);
      for (int k = 0; k < run_len && n < budget; k++) begin
        raw = pat;
        if (cfg_db <= 8'd16 && $urandom_range(0, 9) == 0) begin
          raw = pat ^ btn_vec_t'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 59) == 0) begin
          clock_ms = $urandom();
        end else begin
          clock_ms += $urandom_range(0, span);
        end
        stamp = ($urandom_range(0, 49) == 0) ? 32'd0 : clock_ms;
        send_tick(raw, stamp);
        n++;
        if (n == budget / 2) begin
          if (holdoff) holdoff_asked++;
          if (pause) drain();
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero stamp, press, repeat, all pressed at top of time, wrap, release
    send_tick(8'hFF, 32'd0);
    send_tick(8'hFE, 32'd5);
    send_tick(8'hFE, 32'd6);
    send_tick(8'hFE, 32'd7);
    send_tick(8'hFE, 32'd500);
    repeat (3) send_tick(8'h00, 32'hFFFF_FFFF);
    send_tick(8'h00, 32'h0000_0063);
    repeat (3) send_tick(8'hFF, 32'h8000_0000);

    // no debounce, no hold, no repeat: double firing and saturation
    apply_cfg(8'd0, 16'd0, 16'd0, 7'd127, 7'd127);
    send_tick(8'h7F, 32'd100);
    send_tick(8'h7F, 32'd100);
    send_tick(8'hAA, 32'd200);
    send_tick(8'h55, 32'd0);

    // limit lowered below offsets, step zero
    apply_cfg(8'd1, 16'hFFFF, 16'hFFFF, 7'd0, 7'd5);
    send_tick(8'hFF, 32'd300);
    send_tick(8'hFE, 32'd301);
    send_tick(8'hFE, 32'd302);
    send_tick(8'hBF, 32'd303);

    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: apply_cfg(DEF_DEBOUNCE_SAMPLES, DEF_HOLD_DELAY_MS, DEF_REPEAT_INTERVAL_MS,
                     DEF_TRIM_STEP, DEF_TRIM_LIMIT);
        1: apply_cfg(8'd1, 16'd0, 16'd0, 7'd1, 7'd127);
        2: apply_cfg(8'd2, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127);
        3: apply_cfg(8'd0, 16'($urandom_range(0, 300)), 16'($urandom_range(0, 100)),
                     7'd0, 7'd0);
        4: apply_cfg(8'd255, 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 500)),
                     7'($urandom_range(1, 127)), 7'($urandom_range(0, 127)));
        default: apply_cfg(8'($urandom_range(1, 6)), 16'($urandom_range(0, 800)),
                           16'($urandom_range(0, 300)), 7'($urandom_range(1, 127)),
                           7'($urandom_range(0, 127)));
      endcase
      gaps_on    = (ph % 3 != 0);
      burst_left = $urandom_range(1, 12);
      stall_mode = (ph % 3 == 0) ? STALL_NONE : stall_kind_t'(ph % 4);
      run_phase((ph == 4) ? 500 : 130, ph == 2 || ph == 7, ph == 5);
    end

    in_valid   <= 1'b0;
    stall_mode = STALL_RANDOM;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (pending_count != 0 && wait_cycles < 5000);
    repeat (10) @(posedge clk);
    if (pending_count != 0) begin
      $error("%0d expected results never arrived", pending_count);
    end

    $display("Run covered %0d ticks over %0d register settings; %0d results checked,",
             sent, settings, checked_count);
    $display("%0d of them with trim activity.", active_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
